// ----- hw/rtl/tpj_pkg.sv -----
// ----------------------------------------------------------------------------
// tpj_pkg
// Shared types and codes for the two-joint trapezoidal profile generator.
// ----------------------------------------------------------------------------
package tpj_pkg;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_SQRT
    } t_ar_op;

    typedef struct packed {
        logic        start;
        t_ar_op      op;
        logic [63:0] opa;
        logic [31:0] opb;
    } t_ar_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [95:0] res;
    } t_ar_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,
        ST_QDIV,
        ST_RAMP,
        ST_DUR,
        ST_RATIO,
        ST_SQRT,
        ST_AMUL,
        ST_ADIV,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_FINISH
    } t_state;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    localparam logic [1:0] REG_VMAX = 2'd0;
    localparam logic [1:0] REG_AMAX = 2'd1;
    localparam logic [1:0] REG_STEP = 2'd2;

endpackage

// ----- hw/rtl/tpj_arith.sv -----
// ----------------------------------------------------------------------------
// tpj_arith
// Shared iterative unit: shift-add multiply, restoring divide and square root.
// ----------------------------------------------------------------------------
module tpj_arith (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpj_pkg::t_ar_cmd i_cmd,
    output tpj_pkg::t_ar_rsp o_rsp
);
    import tpj_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_ar_op      r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [95:0] r_acc, n_acc;
    logic [63:0] r_opd, n_opd;
    logic [33:0] r_rem, n_rem;

    logic [64:0] w_sum;
    logic [32:0] w_drr;
    logic [32:0] w_ddif;
    logic [35:0] w_srr;
    logic [35:0] w_trial;
    logic [35:0] w_sdif;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_opd  = r_opd;
        n_rem  = r_rem;
        w_sum   = {1'b0, r_acc[95:32]} + (r_acc[0] ? {1'b0, r_opd} : 65'd0);
        w_drr   = {r_rem[31:0], r_acc[63]};
        w_ddif  = w_drr - {1'b0, r_opd[31:0]};
        w_srr   = {r_rem, r_acc[63:62]};
        w_trial = {2'b00, r_opd[31:0], 2'b01};
        w_sdif  = w_srr - w_trial;
        if (i_cmd.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_rem  = '0;
            unique case (i_cmd.op)
                AR_MUL: begin
                    n_acc = {64'd0, i_cmd.opb};
                    n_opd = i_cmd.opa;
                    n_cnt = 6'd31;
                end
                AR_DIV: begin
                    n_acc = {32'd0, i_cmd.opa};
                    n_opd = {32'd0, i_cmd.opb};
                    n_cnt = 6'd63;
                end
                default: begin
                    n_acc = {32'd0, i_cmd.opa};
                    n_opd = '0;
                    n_cnt = 6'd31;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                AR_MUL: begin
                    n_acc = {w_sum, r_acc[31:1]};
                end
                AR_DIV: begin
                    if (w_drr >= {1'b0, r_opd[31:0]}) begin
                        n_rem = {2'b00, w_ddif[31:0]};
                        n_acc = {32'd0, r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = {2'b00, w_drr[31:0]};
                        n_acc = {32'd0, r_acc[62:0], 1'b0};
                    end
                end
                default: begin
                    n_acc = {32'd0, r_acc[61:0], 2'b00};
                    if (w_srr >= w_trial) begin
                        n_rem = w_sdif[33:0];
                        n_opd = {32'd0, r_opd[30:0], 1'b1};
                    end else begin
                        n_rem = w_srr[33:0];
                        n_opd = {32'd0, r_opd[30:0], 1'b0};
                    end
                end
            endcase
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_opd <= n_opd;
        r_rem <= n_rem;
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        unique case (r_op)
            AR_MUL:  o_rsp.res = r_acc;
            AR_DIV:  o_rsp.res = {r_rem[31:0], r_acc[63:0]};
            default: o_rsp.res = {64'd0, r_opd[31:0]};
        endcase
    end

endmodule

// ----- hw/rtl/trapezoid_profile_two_joint.sv -----
// ----------------------------------------------------------------------------
// trapezoid_profile_two_joint
// Two-joint synchronised trapezoidal velocity profile generator.
// A start transfer runs ten to fourteen multiply, divide or square-root passes
// of the shared unit and then loads the output register. A tick transfer
// runs six multiplies and the load; an idle tick only loads the output.
// One transfer is in work at a time, and a held output register stalls the
// next load.
// Reset is synchronous and active low; it clears the plan and leaves idle.
// ----------------------------------------------------------------------------
module trapezoid_profile_two_joint #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // start_j0, start_j1, goal_j0, goal_j1
    input  logic [127:0] i_s_axis_tdata,
    // operation
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_j0, pos_j1, vel_j0, vel_j1, acc_j0, acc_j1, phase, zero padding
    output logic [199:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    // valid_res
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import tpj_pkg::*;

    localparam logic [31:0] ONE_Q   = 32'd1 << FRAC_BITS;
    localparam logic [95:0] CAP62   = 96'd1 << 62;
    localparam int          HI_BITS = 64 - FRAC_BITS;

    t_ar_cmd w_cmd;
    t_ar_rsp w_rsp;

    t_state             r_state, n_state;
    logic               r_go, n_go;
    logic               r_j, n_j;
    logic [31:0]        r_vmax, n_vmax;
    logic [31:0]        r_amax, n_amax;
    logic [15:0]        r_dt, n_dt;
    logic signed [31:0] r_orig [2];
    logic signed [31:0] n_orig [2];
    logic signed [31:0] r_targ [2];
    logic signed [31:0] n_targ [2];
    logic signed [31:0] r_jacc [2];
    logic signed [31:0] n_jacc [2];
    logic [63:0]        r_vv, n_vv;
    logic [31:0]        r_ramp, n_ramp;
    logic [31:0]        r_dur, n_dur;
    logic [31:0]        r_t, n_t;
    logic               r_cruise, n_cruise;
    logic               r_moving, n_moving;
    logic [63:0]        r_tmp, n_tmp;
    logic [63:0]        r_m, n_m;
    logic [31:0]        r_pos [2];
    logic [31:0]        n_pos [2];
    logic [31:0]        r_vel [2];
    logic [31:0]        n_vel [2];
    logic [31:0]        r_acco [2];
    logic [31:0]        n_acco [2];
    logic [1:0]         r_ph, n_ph;
    logic               r_last, n_last;
    logic               r_vres, n_vres;
    logic               r_out_valid, n_out_valid;
    logic [199:0]       r_out_data, n_out_data;
    logic               r_out_last, n_out_last;
    logic               r_out_user, n_out_user;

    logic signed [32:0] w_h [2];
    logic [32:0]        w_habs [2];
    logic [31:0]        w_mag [2];
    logic [31:0]        w_hmax;
    logic [31:0]        w_v, w_a;
    logic [1:0]         w_ph;
    logic [31:0]        w_r, w_tc;
    logic signed [31:0] w_ja;
    logic               w_aneg;
    logic [31:0]        w_ua;
    logic [95:0]        w_sh;
    logic [63:0]        w_msh;
    logic               w_last;
    logic               w_trap;
    logic [64:0]        w_dsum;
    logic [31:0]        w_um;
    logic signed [65:0] w_base, w_pos, w_velm, w_accx;
    logic               w_sub;
    logic               w_arith;

    function automatic logic [31:0] f_sat_u(input logic [64:0] v);
        f_sat_u = (|v[64:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [63:0] f_cap(input logic [95:0] v);
        f_cap = (v > CAP62) ? CAP62[63:0] : v[63:0];
    endfunction

    function automatic logic [31:0] f_sat_s(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            f_sat_s = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            f_sat_s = 32'h8000_0000;
        end else begin
            f_sat_s = v[31:0];
        end
    endfunction

    tpj_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        for (int n = 0; n < 2; n++) begin
            w_h[n]    = {r_targ[n][31], r_targ[n]} - {r_orig[n][31], r_orig[n]};
            w_habs[n] = w_h[n][32] ? 33'(-w_h[n]) : 33'(w_h[n]);
            w_mag[n]  = w_habs[n][31:0];
        end
        w_hmax = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
        w_v    = (r_vmax == 32'd0) ? 32'd1 : r_vmax;
        w_a    = (r_amax == 32'd0) ? 32'd1 : r_amax;
        if (r_t <= r_ramp) begin
            w_ph = PH_ACCEL;
        end else if (r_cruise && (r_t <= r_dur - r_ramp)) begin
            w_ph = PH_CRUISE;
        end else begin
            w_ph = PH_DECEL;
        end
        w_r    = r_dur - r_t;
        w_tc   = r_t - (r_ramp >> 1);
        w_ja   = r_jacc[r_j];
        w_aneg = w_ja[31];
        w_ua   = w_aneg ? (~w_ja + 32'd1) : w_ja;
        if (r_state == ST_SB && w_ph != PH_CRUISE) begin
            w_sh = w_rsp.res >> (FRAC_BITS + 1);
        end else begin
            w_sh = w_rsp.res >> FRAC_BITS;
        end
        w_msh  = f_cap(w_sh);
        w_last = ({1'b0, r_t} + {17'd0, r_dt}) > {1'b0, r_dur};
        w_trap = ({32'd0, w_hmax} > w_rsp.res[63:0]) ||
                 (({32'd0, w_hmax} == w_rsp.res[63:0]) && (w_rsp.res[95:64] == 32'd0));
        w_dsum = {1'b0, w_rsp.res[63:0]} + {33'd0, r_ramp};
        w_um   = (|w_rsp.res[63:31]) ? 32'h8000_0000 : w_rsp.res[31:0];
        w_sub  = (w_ph == PH_DECEL) ^ w_aneg;
        w_base = (w_ph == PH_DECEL) ? 66'(r_targ[r_j]) : 66'(r_orig[r_j]);
        w_pos  = w_sub ? (w_base - $signed({2'b00, r_m})) : (w_base + $signed({2'b00, r_m}));
        w_velm = w_aneg ? -$signed({2'b00, w_msh}) : $signed({2'b00, w_msh});
        unique case (w_ph)
            PH_ACCEL:  w_accx = 66'(w_ja);
            PH_CRUISE: w_accx = '0;
            default:   w_accx = -66'(w_ja);
        endcase
    end

    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.op    = AR_MUL;
        w_cmd.opa   = '0;
        w_cmd.opb   = '0;
        w_arith     = 1'b1;
        unique case (r_state)
            ST_VV: begin
                w_cmd.opa = {32'd0, w_v};
                w_cmd.opb = w_v;
            end
            ST_QDIV: begin
                w_cmd.op  = AR_DIV;
                w_cmd.opa = r_vv;
                w_cmd.opb = w_a;
            end
            ST_RAMP: begin
                w_cmd.op  = AR_DIV;
                w_cmd.opa = {32'd0, w_v} << FRAC_BITS;
                w_cmd.opb = w_a;
            end
            ST_DUR: begin
                w_cmd.op  = AR_DIV;
                w_cmd.opa = {32'd0, w_hmax} << FRAC_BITS;
                w_cmd.opb = w_v;
            end
            ST_RATIO: begin
                w_cmd.op  = AR_DIV;
                w_cmd.opa = {32'd0, w_hmax} << FRAC_BITS;
                w_cmd.opb = w_a;
            end
            ST_SQRT: begin
                w_cmd.op  = AR_SQRT;
                w_cmd.opa = r_tmp;
            end
            ST_AMUL: begin
                w_cmd.opa = {32'd0, w_a};
                w_cmd.opb = w_mag[r_j];
                w_arith   = (w_hmax != 32'd0);
            end
            ST_ADIV: begin
                w_cmd.op  = AR_DIV;
                w_cmd.opa = r_tmp;
                w_cmd.opb = w_hmax;
            end
            ST_SA: begin
                unique case (w_ph)
                    PH_ACCEL: begin
                        w_cmd.opa = {32'd0, r_t};
                        w_cmd.opb = r_t;
                    end
                    PH_CRUISE: begin
                        w_cmd.opa = {32'd0, w_ua};
                        w_cmd.opb = r_ramp;
                    end
                    default: begin
                        w_cmd.opa = {32'd0, w_r};
                        w_cmd.opb = w_r;
                    end
                endcase
            end
            ST_SB: begin
                w_cmd.opa = r_tmp;
                w_cmd.opb = (w_ph == PH_CRUISE) ? w_tc : w_ua;
            end
            ST_SC: begin
                w_cmd.opa = {32'd0, w_ua};
                unique case (w_ph)
                    PH_ACCEL:  w_cmd.opb = r_t;
                    PH_CRUISE: w_cmd.opb = r_ramp;
                    default:   w_cmd.opb = w_r;
                endcase
            end
            default: w_arith = 1'b0;
        endcase
        w_cmd.start = w_arith && !r_go;
    end

    always_comb begin
        n_state     = r_state;
        n_go        = r_go;
        n_j         = r_j;
        n_vmax      = r_vmax;
        n_amax      = r_amax;
        n_dt        = r_dt;
        n_orig      = r_orig;
        n_targ      = r_targ;
        n_jacc      = r_jacc;
        n_vv        = r_vv;
        n_ramp      = r_ramp;
        n_dur       = r_dur;
        n_t         = r_t;
        n_cruise    = r_cruise;
        n_moving    = r_moving;
        n_tmp       = r_tmp;
        n_m         = r_m;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_acco      = r_acco;
        n_ph        = r_ph;
        n_last      = r_last;
        n_vres      = r_vres;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_VMAX: n_vmax = i_cfg_data;
                REG_AMAX: n_amax = i_cfg_data;
                REG_STEP: n_dt   = i_cfg_data[15:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_cmd.start) begin
            n_go = 1'b1;
        end
        if (w_rsp.done) begin
            n_go = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        n_orig[0] = i_s_axis_tdata[31:0];
                        n_orig[1] = i_s_axis_tdata[63:32];
                        n_targ[0] = i_s_axis_tdata[95:64];
                        n_targ[1] = i_s_axis_tdata[127:96];
                        n_moving  = 1'b1;
                        n_state   = ST_VV;
                    end else if (r_moving) begin
                        n_t     = r_t + {16'd0, r_dt};
                        n_j     = 1'b0;
                        n_state = ST_SA;
                    end else begin
                        n_pos[0]  = r_targ[0];
                        n_pos[1]  = r_targ[1];
                        n_vel[0]  = '0;
                        n_vel[1]  = '0;
                        n_acco[0] = '0;
                        n_acco[1] = '0;
                        n_ph      = PH_IDLE;
                        n_last    = 1'b0;
                        n_vres    = 1'b0;
                        n_state   = ST_FINISH;
                    end
                end
            end
            ST_VV: begin
                if (w_rsp.done) begin
                    n_vv    = w_rsp.res[63:0];
                    n_state = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (w_rsp.done) begin
                    n_cruise = {32'd0, w_hmax} > w_rsp.res[63:0];
                    n_state  = w_trap ? ST_RAMP : ST_RATIO;
                end
            end
            ST_RAMP: begin
                if (w_rsp.done) begin
                    n_ramp  = f_sat_u({1'b0, w_rsp.res[63:0]});
                    n_state = ST_DUR;
                end
            end
            ST_DUR: begin
                if (w_rsp.done) begin
                    n_dur   = f_sat_u(w_dsum);
                    n_j     = 1'b0;
                    n_state = ST_AMUL;
                end
            end
            ST_RATIO: begin
                if (w_rsp.done) begin
                    if (|w_rsp.res[63:HI_BITS]) begin
                        n_ramp  = 32'hFFFF_FFFF;
                        n_dur   = 32'hFFFF_FFFF;
                        n_j     = 1'b0;
                        n_state = ST_AMUL;
                    end else begin
                        n_tmp   = w_rsp.res[63:0] << FRAC_BITS;
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (w_rsp.done) begin
                    n_ramp  = w_rsp.res[31:0];
                    n_dur   = f_sat_u({32'd0, w_rsp.res[31:0], 1'b0});
                    n_j     = 1'b0;
                    n_state = ST_AMUL;
                end
            end
            ST_AMUL: begin
                if (w_hmax == 32'd0) begin
                    n_jacc[r_j] = '0;
                    if (r_j == 1'b0) begin
                        n_j = 1'b1;
                    end else begin
                        n_j     = 1'b0;
                        n_t     = '0;
                        n_state = ST_SA;
                    end
                end else if (w_rsp.done) begin
                    n_tmp   = w_rsp.res[63:0];
                    n_state = ST_ADIV;
                end
            end
            ST_ADIV: begin
                if (w_rsp.done) begin
                    if (w_h[r_j][32]) begin
                        n_jacc[r_j] = ~w_um + 32'd1;
                    end else begin
                        n_jacc[r_j] = (w_um == 32'h8000_0000) ? 32'h7FFF_FFFF : w_um;
                    end
                    if (r_j == 1'b0) begin
                        n_j     = 1'b1;
                        n_state = ST_AMUL;
                    end else begin
                        n_j     = 1'b0;
                        n_t     = '0;
                        n_state = ST_SA;
                    end
                end
            end
            ST_SA: begin
                if (w_rsp.done) begin
                    n_tmp   = w_msh;
                    n_state = ST_SB;
                end
            end
            ST_SB: begin
                if (w_rsp.done) begin
                    n_m     = w_msh;
                    n_state = ST_SC;
                end
            end
            ST_SC: begin
                if (w_rsp.done) begin
                    n_pos[r_j]  = f_sat_s(w_pos);
                    n_vel[r_j]  = f_sat_s(w_velm);
                    n_acco[r_j] = f_sat_s(w_accx);
                    if (r_j == 1'b0) begin
                        n_j     = 1'b1;
                        n_state = ST_SA;
                    end else begin
                        n_ph    = w_ph;
                        n_last  = w_last;
                        n_vres  = 1'b1;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_ph, r_acco[1], r_acco[0], r_vel[1], r_vel[0],
                                   r_pos[1], r_pos[0]};
                    n_out_last  = r_last;
                    n_out_user  = r_vres;
                    if (r_vres && r_last) begin
                        n_moving = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_j         <= 1'b0;
            r_vmax      <= ONE_Q;
            r_amax      <= ONE_Q;
            r_dt        <= 16'd655;
            r_orig      <= '{default: '0};
            r_targ      <= '{default: '0};
            r_jacc      <= '{default: '0};
            r_ramp      <= '0;
            r_dur       <= '0;
            r_t         <= '0;
            r_cruise    <= 1'b0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_j         <= n_j;
            r_vmax      <= n_vmax;
            r_amax      <= n_amax;
            r_dt        <= n_dt;
            r_orig      <= n_orig;
            r_targ      <= n_targ;
            r_jacc      <= n_jacc;
            r_ramp      <= n_ramp;
            r_dur       <= n_dur;
            r_t         <= n_t;
            r_cruise    <= n_cruise;
            r_moving    <= n_moving;
            r_out_valid <= n_out_valid;
        end
        r_vv       <= n_vv;
        r_tmp      <= n_tmp;
        r_m        <= n_m;
        r_pos      <= n_pos;
        r_vel      <= n_vel;
        r_acco     <= n_acco;
        r_ph       <= n_ph;
        r_last     <= n_last;
        r_vres     <= n_vres;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_rsp.busy)
        else $error("Shared unit busy while the sequencer is idle.");

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_go)
        else $error("Shared unit finished without an issued operation.");

    a_last_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("Final sample marked on an idle transfer.");

endmodule

// ----- tb/tb_trapezoid_profile_two_joint.sv -----
// ----------------------------------------------------------------------------
// tb_trapezoid_profile_two_joint
// Self-checking testbench for the two-joint trapezoidal profile generator.
// Start and tick transfers are driven on the input stream. A bit-accurate
// profile predictor forms each expected sample, and every output transfer is
// compared field by field in order. Both streams stall at random, and the
// limit registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_trapezoid_profile_two_joint;
    import tpj_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct {
        logic [31:0] word [6];
        logic [1:0]  phase;
        logic        last;
        logic        valid;
    } t_sample;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [199:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         o_m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    trapezoid_profile_two_joint dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [63:0] vmax_reg, amax_reg, step_reg;
    longint      org_ang [2], tgt_ang [2], jnt_acc [2];
    logic [63:0] ramp_t, move_t, now_t;
    logic        cruise_on, in_motion;

    t_sample     pending_samples [$];
    int          errors = 0;
    logic        calm = 1'b0;
    int          stall_left = 0;

    function automatic logic [63:0] mul_shift(logic [63:0] x, logic [63:0] y, int s);
        logic [127:0] p;
        p = ({64'd0, x} * {64'd0, y}) >> s;
        return (p > {64'd0, CAP62}) ? CAP62 : p[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint signed_mag(longint a, logic [63:0] m);
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] sat_time(logic [63:0] v);
        return (v > MAX32) ? MAX32 : v;
    endfunction

    function automatic void plan_move(logic [127:0] d);
        logic [63:0] mag [2];
        logic [63:0] hmax, v, a, vv, q, rem, ratio, um;
        longint h;
        for (int n = 0; n < 2; n++) begin
            org_ang[n] = longint'(signed'(d[32*n +: 32]));
            tgt_ang[n] = longint'(signed'(d[64 + 32*n +: 32]));
            h = tgt_ang[n] - org_ang[n];
            mag[n] = (h < 0) ? -h : h;
        end
        hmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
        v = (vmax_reg != 0) ? vmax_reg : 64'd1;
        a = (amax_reg != 0) ? amax_reg : 64'd1;
        vv = v * v;
        q = vv / a;
        rem = vv % a;
        if (hmax > q || (hmax == q && rem == 0)) begin
            ramp_t = sat_time((v << FRAC) / a);
            move_t = sat_time((hmax << FRAC) / v + ramp_t);
            cruise_on = hmax > q;
        end else begin
            ratio = (hmax << FRAC) / a;
            if ((ratio >> (64 - FRAC)) != 0) ramp_t = MAX32;
            else ramp_t = sat_time(floor_sqrt(ratio << FRAC));
            move_t = sat_time(2 * ramp_t);
            cruise_on = 1'b0;
        end
        for (int n = 0; n < 2; n++) begin
            jnt_acc[n] = 0;
            if (hmax != 0) begin
                um = (mag[n] * a) / hmax;
                if (um > 64'h8000_0000) um = 64'h8000_0000;
                jnt_acc[n] = clamp32(signed_mag(tgt_ang[n] - org_ang[n], um));
            end
        end
    endfunction

    function automatic void profile_sample(logic [63:0] t, output t_sample s);
        logic [1:0]  ph;
        logic [63:0] ua, m, vm, r;
        longint      a, pos, vel, acc;
        if (t <= ramp_t) ph = PH_ACCEL;
        else if (cruise_on && t <= move_t - ramp_t) ph = PH_CRUISE;
        else ph = PH_DECEL;
        for (int n = 0; n < 2; n++) begin
            a = jnt_acc[n];
            ua = (a < 0) ? -a : a;
            if (ph == PH_ACCEL) begin
                m = mul_shift(ua, mul_shift(t, t, FRAC), FRAC + 1);
                pos = org_ang[n] + signed_mag(a, m);
                vel = signed_mag(a, mul_shift(ua, t, FRAC));
                acc = a;
            end else if (ph == PH_CRUISE) begin
                vm = mul_shift(ua, ramp_t, FRAC);
                m = mul_shift(vm, t - (ramp_t >> 1), FRAC);
                pos = org_ang[n] + signed_mag(a, m);
                vel = signed_mag(a, vm);
                acc = 0;
            end else begin
                r = move_t - t;
                m = mul_shift(ua, mul_shift(r, r, FRAC), FRAC + 1);
                pos = tgt_ang[n] - signed_mag(a, m);
                vel = signed_mag(a, mul_shift(ua, r, FRAC));
                acc = -a;
            end
            s.word[n] = 32'(clamp32(pos));
            s.word[2 + n] = 32'(clamp32(vel));
            s.word[4 + n] = 32'(clamp32(acc));
        end
        s.phase = ph;
    endfunction

    function automatic t_sample predict_profile(logic op, logic [127:0] d);
        t_sample     s;
        logic [63:0] t;
        if (op == OP_START) begin
            plan_move(d);
            in_motion = 1'b1;
            t = 0;
        end else if (in_motion) begin
            t = now_t + step_reg;
        end else begin
            s.word[0] = 32'(clamp32(tgt_ang[0]));
            s.word[1] = 32'(clamp32(tgt_ang[1]));
            for (int k = 2; k < 6; k++) s.word[k] = '0;
            s.phase = PH_IDLE;
            s.last = 1'b0;
            s.valid = 1'b0;
            return s;
        end
        now_t = t;
        profile_sample(t, s);
        s.last = (t + step_reg > move_t);
        if (s.last) in_motion = 1'b0;
        s.valid = 1'b1;
        return s;
    endfunction

    // Output side: random back-pressure and in-order comparison.
    always @(negedge i_clk) begin
        if (calm) begin
            i_m_axis_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %h", $time,
                         o_m_axis_tdata);
                errors++;
            end else begin
                e = pending_samples.pop_front();
                for (int k = 0; k < 6; k++)
                    if (o_m_axis_tdata[32*k +: 32] !== e.word[k]) begin
                        $display("%0t: word %0d expected %h actual %h", $time, k,
                                 e.word[k], o_m_axis_tdata[32*k +: 32]);
                        errors++;
                    end
                if (o_m_axis_tdata[193:192] !== e.phase) begin
                    $display("%0t: phase expected %0d actual %0d", $time, e.phase,
                             o_m_axis_tdata[193:192]);
                    errors++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last,
                             o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tuser !== e.valid) begin
                    $display("%0t: valid_res expected %b actual %b", $time, e.valid,
                             o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [127:0] d);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = op;
        i_s_axis_tdata = d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_samples.push_back(predict_profile(op, d));
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic drain_samples();
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_VMAX) vmax_reg = {32'd0, val};
        else if (idx == REG_AMAX) amax_reg = {32'd0, val};
        else if (idx == REG_STEP) step_reg = {48'd0, val[15:0]};
    endtask

    task automatic set_limits(logic [31:0] v, logic [31:0] a, logic [15:0] dt);
        drain_samples();
        write_reg(REG_VMAX, v);
        write_reg(REG_AMAX, a);
        write_reg(REG_STEP, {16'd0, dt});
    endtask

    function automatic logic [127:0] move_words(logic [31:0] s0, logic [31:0] s1,
                                                logic [31:0] g0, logic [31:0] g1);
        return {g1, g0, s1, s0};
    endfunction

    function automatic logic [127:0] random_words();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] short_move();
        logic [31:0] s0, s1, span;
        span = $urandom_range(0, 3) == 0 ? 32'h0000_4000 : 32'h0002_0000;
        s0 = $urandom;
        s1 = s0 + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        return move_words(s0, s1, s0 + $urandom_range(0, span) - (span >> 1),
                          s1 + $urandom_range(0, span) - (span >> 1));
    endfunction

    task automatic test_idle_after_reset();
        repeat (3) send_item(OP_TICK, random_words());
        send_item(OP_START, move_words(32'h0, 32'h0, 32'h0, 32'h0));
        send_item(OP_TICK, '0);
    endtask

    task automatic test_profile_shapes();
        set_limits(32'h0001_0000, 32'h0001_0000, 16'd6554);
        // Long trapezoid with a cruise, run to its final sample.
        send_item(OP_START, move_words(32'h0, 32'h0, 32'h0003_0000, 32'hFFFF_0000));
        while (in_motion) send_item(OP_TICK, '0);
        // Move exactly long enough to reach the velocity limit.
        send_item(OP_START, move_words(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0));
        while (in_motion) send_item(OP_TICK, '0);
        // Short triangular move, then ticks once idle.
        send_item(OP_START, move_words(32'h0, 32'h0, 32'hFFFF_C000, 32'h0000_2000));
        while (in_motion) send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_START, move_words(32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h8000_0000, 32'h7FFF_FFFF));
        send_item(OP_TICK, '0);
        send_item(OP_START, move_words(32'h1234_0000, 32'h1234_0000,
                                       32'h1234_0000, 32'h1234_0000));
        send_item(OP_TICK, '0);
    endtask

    task automatic test_register_extremes();
        set_limits(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF);
        send_item(OP_START, move_words(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h1));
        send_item(OP_TICK, '0);
        set_limits(32'h0000_0001, 32'hFFFF_FFFF, 16'd1);
        send_item(OP_START, move_words(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        send_item(OP_TICK, '0);
        set_limits(32'h0, 32'h0, 16'd0);
        send_item(OP_START, move_words(32'h0, 32'h0, 32'h0000_0100, 32'h0000_0080));
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd655);
        drain_samples();
        // Index three addresses no register and must be ignored.
        i_cfg_we = 1'b1;
        i_cfg_index = 2'd3;
        i_cfg_data = 32'h0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        send_item(OP_START, move_words(32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000));
        while (in_motion) send_item(OP_TICK, '0);
    endtask

    task automatic test_random_moves(int count);
        int pick;
        set_limits($urandom_range(32'h8000, 32'h4_0000), $urandom_range(32'h8000, 32'h4_0000),
                   16'($urandom_range(2000, 20000)));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) send_item(OP_START, random_words());
            else if (pick < 7) send_item(1'($urandom_range(0, 1)), random_words());
            else if (!in_motion && pick < 80) send_item(OP_START, short_move());
            else if (in_motion && pick < 10) send_item(OP_START, short_move());
            else send_item(OP_TICK, random_words());
        end
    endtask

    initial begin
        vmax_reg = 64'h1_0000;
        amax_reg = 64'h1_0000;
        step_reg = 64'd655;
        org_ang = '{0, 0};
        tgt_ang = '{0, 0};
        jnt_acc = '{0, 0};
        ramp_t = 0;
        move_t = 0;
        now_t = 0;
        cruise_on = 1'b0;
        in_motion = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_idle_after_reset();
        test_profile_shapes();
        test_register_extremes();
        for (int p = 0; p < 4; p++) test_random_moves(280);
        calm = 1'b1;
        test_random_moves(120);
        drain_samples();
        repeat (300) @(negedge i_clk);
        if (errors == 0 && pending_samples.size() == 0) begin
            $display("trapezoid_profile_two_joint: match");
        end else begin
            $display("trapezoid_profile_two_joint: mismatch");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("trapezoid_profile_two_joint: mismatch");
        $finish;
    end

endmodule
